// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that holds at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) cond) else $error(msg);

`endif

// ----- design/smss_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted matrix staircase search package
// Request kinds, walk states and the result record shared by the modules.
// ----------------------------------------------------------------------------
package smss_pkg;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic {
      WALK_IDLE = 1'b0,
      WALK_STEP = 1'b1
   } walk_state_type;

   localparam int unsigned ENTRY_W = 32;
   localparam int unsigned INDEX_W = 2;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
   } result_type;

endpackage

// ----- design/smss_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/smss_walk.sv -----
// ----------------------------------------------------------------------------
// Staircase walk engine
// From top-right, one read and compare a cycle; final step waits for out_free.
// ----------------------------------------------------------------------------
module smss_walk #(
   parameter int ROWS = 4,
   parameter int COLS = 4,
   localparam int AW  = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1,
   localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [smss_pkg::ENTRY_W-1:0]    key,
   input  logic                            out_free,
   output logic                            busy,
   output logic                            done,
   output smss_pkg::result_type            result,
   output logic [AW-1:0]                   rd_addr,
   input  logic [smss_pkg::ENTRY_W-1:0]    rd_data
);

   smss_pkg::walk_state_type state_ff, state_in;

   logic [smss_pkg::ENTRY_W-1:0] key_ff, key_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [RIW-1:0]               row_ff, row_in;
   logic [CIW-1:0]               col_ff, col_in;

   logic is_equal;
   logic is_less;
   logic at_bottom;
   logic at_left;
   logic finish;
   logic go_down;
   logic go_left;

   always_comb begin
      is_equal  = (rd_data == key_ff);
      is_less   = ($signed(rd_data) < $signed(key_ff));
      at_bottom = (row_ff == RIW'(ROWS - 1));
      at_left   = (col_ff == '0);
      finish    = 1'b0;
      go_down   = 1'b0;
      go_left   = 1'b0;
      if (state_ff == smss_pkg::WALK_STEP) begin
         if (is_equal || (is_less && at_bottom) || (!is_less && at_left)) begin
            finish = out_free;
         end else if (is_less) begin
            go_down = 1'b1;
         end else begin
            go_left = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smss_pkg::WALK_IDLE: begin
            if (start) begin
               state_in = smss_pkg::WALK_STEP;
            end
         end
         smss_pkg::WALK_STEP: begin
            if (finish) begin
               state_in = smss_pkg::WALK_IDLE;
            end
         end
         default: state_in = smss_pkg::WALK_IDLE;
      endcase
   end

   always_comb begin
      key_in  = key_ff;
      addr_in = addr_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      case (state_ff)
         smss_pkg::WALK_IDLE: begin
            key_in  = key;
            addr_in = AW'(COLS - 1);
            row_in  = '0;
            col_in  = CIW'(COLS - 1);
         end
         smss_pkg::WALK_STEP: begin
            if (go_down) begin
               addr_in = addr_ff + AW'(COLS);
               row_in  = row_ff + RIW'(1);
            end else if (go_left) begin
               addr_in = addr_ff - AW'(1);
               col_in  = col_ff - CIW'(1);
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   always_comb begin
      busy         = (state_ff != smss_pkg::WALK_IDLE);
      done         = finish;
      rd_addr      = addr_in;
      result.found = is_equal;
      result.row   = is_equal ? smss_pkg::INDEX_W'(row_ff) : '0;
      result.col   = is_equal ? smss_pkg::INDEX_W'(col_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smss_pkg::WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff  <= key_in;
      addr_ff <= addr_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
   end

endmodule

// ----- design/sorted_matrix_staircase_search_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted matrix staircase search unit
// Stores a row- and column-sorted matrix and searches it for a key.
// ----------------------------------------------------------------------------
// The request channel carries two kinds of request, told apart by req_tuser.
// A write stores one entry at a row and column and gives no response; a
// write outside the matrix is dropped. A search walks the matrix from its
// top-right corner and returns one response with the found flag on
// rsp_tuser and the row and column of the match on rsp_tdata, both zero
// when the key is not held.
// A write is stored when it is taken. A search visits up to ROWS + COLS - 1
// entries of the matrix, since the walk reads one entry of the matrix
// memory per cycle and compares it with the key in the next. req_tready
// stays low while a search is walking.
// The response sits in an output register, so writes and a new search are
// taken while it waits; a search that finishes while the register is still
// full holds its last step until the receiver takes the waiting response.
// Reset clears the control state only; entries read before they were
// written return arbitrary data.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search_unit #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row_index[1:0], col_index[3:2], entry_value[35:4], search_key[67:36]
   input  logic [71:0] req_tdata,
   // op[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found_row[1:0], found_col[3:2]
   output logic [7:0]  rsp_tdata,
   // found[0]
   output logic [0:0]  rsp_tuser
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                         req_take;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [smss_pkg::ENTRY_W-1:0] rd_data;
   logic [AW-1:0]                rd_addr;
   logic                         walk_busy;
   logic                         walk_done;
   logic                         out_free;
   smss_pkg::result_type         walk_result;
   smss_pkg::op_type             req_op;
   logic [1:0]                   req_row_index;
   logic [1:0]                   req_col_index;
   logic [31:0]                  req_entry_value;
   logic [31:0]                  req_search_key;

   logic                 rsp_valid_ff, rsp_valid_in;
   smss_pkg::result_type rsp_data_ff, rsp_data_in;

   always_comb begin
      req_op          = smss_pkg::op_type'(req_tuser[0]);
      req_row_index   = req_tdata[1:0];
      req_col_index   = req_tdata[3:2];
      req_entry_value = req_tdata[35:4];
      req_search_key  = req_tdata[67:36];
      req_tready      = !walk_busy;
      req_take        = req_tvalid && req_tready;
      wr_en           = req_take && (req_op == smss_pkg::OP_WRITE)
                        && (32'(req_row_index) < 32'(ROWS))
                        && (32'(req_col_index) < 32'(COLS));
      wr_addr         = AW'(32'(req_row_index) * 32'(COLS) + 32'(req_col_index));
      out_free        = !rsp_valid_ff || rsp_tready;
   end

   smss_ram #(
      .WIDTH (smss_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smss_walk #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take && (req_op == smss_pkg::OP_SEARCH)),
      .key      (req_search_key),
      .out_free (out_free),
      .busy     (walk_busy),
      .done     (walk_done),
      .result   (walk_result),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (walk_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = walk_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.col, rsp_data_ff.row};
   assign rsp_tuser  = rsp_data_ff.found;

endmodule

// ----- design/smss_checker.sv -----
// ----------------------------------------------------------------------------
// Staircase search port checker
// Watches the ports of the search unit for ordering and response rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic req_write;
   logic req_search;

   assign req_write  = req_tvalid && req_tready && (req_tuser[0] == smss_pkg::OP_WRITE);
   assign req_search = req_tvalid && req_tready && (req_tuser[0] == smss_pkg::OP_SEARCH);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled response changed.")

   `ASSERT_CLK(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[3:0] == 4'b0000, "Miss response carries a nonzero index.")

   `ASSERT_CLK(a_search_busy, clock, reset, req_search |=> !req_tready, "Request taken while a search walks.")

   `ASSERT_CLK(a_write_silent, clock, reset, req_write && !rsp_tvalid |=> !rsp_tvalid, "Write request produced a response.")

   `ASSERT_ALWAYS(a_pad_zero, clock, rsp_tdata[7:4] == 4'b0000 || !rsp_tvalid, "Response padding is not zero.")

endmodule

bind sorted_matrix_staircase_search_unit smss_checker u_smss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
